>>> rtl/tcs_pkg.sv
package tcs_pkg;

    // Fixed field widths
    localparam int BYTE_W    = 8;
    localparam int TEXEL_W   = 32;
    localparam int ADDR_W    = 20;
    localparam int MODE_W    = 2;
    localparam int DIM_REG_W = 10;
    localparam int STRIDE_W  = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;

    // Tile geometry: 16 bytes by 8 rows
    localparam int BLOCK_ROW_BYTES = 16;
    localparam int BLOCK_ROWS      = 8;
    localparam int BLK_X_W         = $clog2(BLOCK_ROW_BYTES);
    localparam int BLK_Y_W         = $clog2(BLOCK_ROWS);

    // Source layouts
    typedef enum logic [MODE_W-1:0] {
        CM_GRAY       = 2'd0,
        CM_GRAY_ALPHA = 2'd1,
        CM_BGR        = 2'd2,
        CM_BGRA       = 2'd3
    } t_color_mode;

    // Packed texel forms
    typedef enum logic [MODE_W-1:0] {
        PF_5650 = 2'd0,
        PF_5551 = 2'd1,
        PF_4444 = 2'd2,
        PF_8888 = 2'd3
    } t_pix_fmt;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLOR_MODE   = 3'd0,
        CFG_PIXEL_FORMAT = 3'd1,
        CFG_IMAGE_WIDTH  = 3'd2,
        CFG_IMAGE_HEIGHT = 3'd3,
        CFG_ROW_STRIDE   = 3'd4,
        CFG_SURF_HEIGHT  = 3'd5
    } t_cfg_reg;

    // Source bytes of one pixel
    typedef struct packed {
        logic [BYTE_W-1:0] b3;
        logic [BYTE_W-1:0] b2;
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b0;
    } t_src_pixel;

endpackage

>>> rtl/tcs_pack.sv
module tcs_pack
    import tcs_pkg::*;
(
    input  t_color_mode        i_mode,
    input  t_pix_fmt           i_fmt,
    input  t_src_pixel         i_pix,
    output logic [TEXEL_W-1:0] o_texel
);

    logic [BYTE_W-1:0] w_r;
    logic [BYTE_W-1:0] w_g;
    logic [BYTE_W-1:0] w_b;
    logic [BYTE_W-1:0] w_a;

    // Channel pick: gray replicates the first byte
    always_comb begin
        if (i_mode == CM_GRAY || i_mode == CM_GRAY_ALPHA) begin
            w_r = i_pix.b0;
            w_g = i_pix.b0;
            w_b = i_pix.b0;
        end else begin
            w_r = i_pix.b2;
            w_g = i_pix.b1;
            w_b = i_pix.b0;
        end
        // Alpha from b3 in BGRA only; else black is transparent, others opaque
        if (i_mode == CM_BGRA) begin
            w_a = i_pix.b3;
        end else if (w_r == 8'h00 && w_g == 8'h00 && w_b == 8'h00) begin
            w_a = 8'h00;
        end else begin
            w_a = 8'hff;
        end
    end

    // Pack, red in the low bits, low channel bits dropped in 16-bit forms
    always_comb begin
        case (i_fmt)
            PF_5650: o_texel = {16'h0000, w_b[7:3], w_g[7:2], w_r[7:3]};
            PF_5551: o_texel = {16'h0000, w_a[7], w_b[7:3], w_g[7:3], w_r[7:3]};
            PF_4444: o_texel = {16'h0000, w_a[7:4], w_b[7:4], w_g[7:4], w_r[7:4]};
            default: o_texel = {w_a, w_b, w_g, w_r};
        endcase
    end

endmodule

>>> rtl/texel_convert_and_swizzle.sv
// Texel converter and swizzler.
// Input stream: one source pixel per beat in raster order, tdata holds four bytes
// (first byte lowest). The pixel is read per color_mode, given an alpha, packed per
// pixel_format and sent out with its byte address in the destination surface.
// The surface is tiled in 16-byte by 8-row blocks when row_stride_bytes >= 16 and
// surface_height >= 8, and linear otherwise; tuser tells which.
// Output stream: one beat per input beat, tlast on the last pixel of the image.
// The result register is loaded on the edge that accepts the input beat. Throughput
// is one pixel per cycle while the output does not stall; the column and row counters
// and one short multiply per address form sit between the input and that register.
// A stall on the output side holds the result and drops s_axis_tready in the same
// cycle; a beat is taken again as soon as the result register is free or drains.
// Reset clears the counters and the output valid and loads the register defaults
// (BGRA, 8888, 1x1 image, 16-byte stride, 8-row surface). Configuration writes
// through i_cfg_* take effect at once and do not restart the raster position.
module texel_convert_and_swizzle
    import tcs_pkg::*;
#(
    parameter int MAX_DIMENSION = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_DAT_W-1:0] i_cfg_wdata,
    // pixel input
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,   // byte_first, byte_second, byte_third, byte_fourth
    // texel output
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [55:0]          m_axis_tdata,   // texel[31:0], byte_address[51:32], zero pad
    output logic                 m_axis_tuser,   // is_tiled
    output logic                 m_axis_tlast    // last_texel
);

    localparam int CW   = $clog2(MAX_DIMENSION);
    localparam int DW   = $clog2(MAX_DIMENSION + 1);
    localparam int CMPW = (DW > DIM_REG_W) ? DW : DIM_REG_W;
    localparam int XBW  = CW + 2;
    localparam int RAW  = CW + STRIDE_W + 1;
    localparam int FW   = (RAW > ADDR_W) ? RAW : ADDR_W;
    localparam int BKW  = RAW - BLK_X_W - BLK_Y_W;
    localparam int PADW = 56 - TEXEL_W - ADDR_W;

    // Configuration registers
    t_color_mode          r_mode;
    t_pix_fmt             r_fmt;
    logic [DIM_REG_W-1:0] r_img_w;
    logic [DIM_REG_W-1:0] r_img_h;
    logic [STRIDE_W-1:0]  r_stride;
    logic [DIM_REG_W-1:0] r_surf_h;

    // Raster position of the next pixel
    logic [CW-1:0] r_col;
    logic [CW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [CW-1:0] n_row;

    // Result register
    logic                r_ovalid;
    logic [TEXEL_W-1:0]  r_texel;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_tiled;
    logic                r_last;

    logic                w_accept;
    logic [DW-1:0]       w_width;
    logic [DW-1:0]       w_height;
    logic                w_last_col;
    logic                w_last_row;
    logic [XBW-1:0]      w_xb;
    logic                w_tiled;
    logic [RAW-1:0]      w_lin;
    logic [RAW-1:0]      w_tile;
    logic [BKW-1:0]      w_blk;
    logic [FW-1:0]       w_addr_full;
    logic [TEXEL_W-1:0]  w_texel;
    t_src_pixel          w_pix;

    function automatic logic [DW-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
        logic [CMPW-1:0] ext;
        ext = CMPW'(v);
        if (v == '0) begin
            clamp_dim = DW'(1);
        end else if (ext > CMPW'(MAX_DIMENSION)) begin
            clamp_dim = DW'(MAX_DIMENSION);
        end else begin
            clamp_dim = DW'(ext);
        end
    endfunction

    assign s_axis_tready = !r_ovalid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_pix         = t_src_pixel'(s_axis_tdata);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= CM_BGRA;
            r_fmt    <= PF_8888;
            r_img_w  <= DIM_REG_W'(1);
            r_img_h  <= DIM_REG_W'(1);
            r_stride <= STRIDE_W'(BLOCK_ROW_BYTES);
            r_surf_h <= DIM_REG_W'(BLOCK_ROWS);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_COLOR_MODE:   r_mode   <= t_color_mode'(i_cfg_wdata[MODE_W-1:0]);
                CFG_PIXEL_FORMAT: r_fmt    <= t_pix_fmt'(i_cfg_wdata[MODE_W-1:0]);
                CFG_IMAGE_WIDTH:  r_img_w  <= i_cfg_wdata[DIM_REG_W-1:0];
                CFG_IMAGE_HEIGHT: r_img_h  <= i_cfg_wdata[DIM_REG_W-1:0];
                CFG_ROW_STRIDE:   r_stride <= i_cfg_wdata[STRIDE_W-1:0];
                CFG_SURF_HEIGHT:  r_surf_h <= i_cfg_wdata[DIM_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Position compare and next position
    always_comb begin
        w_width    = clamp_dim(r_img_w);
        w_height   = clamp_dim(r_img_h);
        w_last_col = (DW'(r_col) + DW'(1)) >= w_width;
        w_last_row = (DW'(r_row) + DW'(1)) >= w_height;
        if (w_last_col) begin
            n_col = '0;
            n_row = w_last_row ? '0 : r_row + CW'(1);
        end else begin
            n_col = r_col + CW'(1);
            n_row = r_row;
        end
    end

    // Byte addressing: linear and 16x8 block-tiled forms
    always_comb begin
        w_xb    = (r_fmt == PF_8888) ? {r_col, 2'b00} : {1'b0, r_col, 1'b0};
        w_tiled = (r_stride >= STRIDE_W'(BLOCK_ROW_BYTES)) &&
                  (r_surf_h >= DIM_REG_W'(BLOCK_ROWS));
        w_lin   = RAW'(r_row * r_stride) + RAW'(w_xb);
        w_blk   = BKW'((r_row >> BLK_Y_W) * (r_stride >> BLK_X_W)) +
                  BKW'(w_xb >> BLK_X_W);
        w_tile  = {w_blk, r_row[BLK_Y_W-1:0], w_xb[BLK_X_W-1:0]};
        w_addr_full = w_tiled ? FW'(w_tile) : FW'(w_lin);
    end

    tcs_pack u_pack (
        .i_mode  (r_mode),
        .i_fmt   (r_fmt),
        .i_pix   (w_pix),
        .o_texel (w_texel)
    );

    // Counters and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (w_accept) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_texel <= w_texel;
            r_addr  <= w_addr_full[ADDR_W-1:0];
            r_tiled <= w_tiled;
            r_last  <= w_last_col && w_last_row;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{PADW{1'b0}}, r_addr, r_texel};
    assign m_axis_tuser  = r_tiled;
    assign m_axis_tlast  = r_last;

endmodule
